// ===== sv/dsf_pkg.sv =====
// ----------------------------------------------------------------------------
// dsf_pkg: shared types and constants of the divisible run finder
// Sizes, microcode encoding, the microprogram and the status record that
// flows from the datapath back to the sequencer.
// ----------------------------------------------------------------------------
package dsf_pkg;

  localparam int unsigned MAX_DIVISOR = 4096;
  localparam int unsigned MAX_SET_LEN = 65536;
  localparam int unsigned VALUE_BITS  = 32;

  localparam int unsigned RES_W     = $clog2(MAX_DIVISOR);     // residue
  localparam int unsigned DIV_W     = RES_W + 1;               // divisor register
  localparam int unsigned POS_W     = $clog2(MAX_SET_LEN) + 1; // item count, reported positions
  localparam int unsigned FIRST_W   = POS_W - 1;               // stored 0-based position
  localparam int unsigned DVD_W     = VALUE_BITS + 1;          // value plus old residue
  localparam int unsigned BIT_CNT_W = $clog2(DVD_W);
  localparam int unsigned EPOCH_W   = 16;
  localparam int unsigned ENTRY_W   = EPOCH_W + FIRST_W;
  localparam int unsigned STEP_W    = 3;
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;

  localparam logic [ADDR_W-1:0] REG_DIVISOR = ADDR_W'(0);

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_WAIT  = 3'd0;
  localparam step_t STEP_DIV   = 3'd1;
  localparam step_t STEP_ADD   = 3'd2;
  localparam step_t STEP_UPD   = 3'd3;
  localparam step_t STEP_END   = 3'd4;
  localparam step_t STEP_SWEEP = 3'd5;

  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_WAIT  = 3'd1,
    OP_DIV   = 3'd2,
    OP_ADD   = 3'd3,
    OP_UPD   = 3'd4,
    OP_EMIT  = 3'd5,
    OP_SWEEP = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    COND_NEXT       = 3'd0,
    COND_GOTO       = 3'd1,
    COND_START      = 3'd2,
    COND_DIV_LOOP   = 3'd3,
    COND_EMIT       = 3'd4,
    COND_SWEEP_LOOP = 3'd5
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic sweep_pend;
    logic in_go;
    logic div_more;
    logic hold_emit;
    logic sweep_last;
  } seq_status_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [FIRST_W-1:0] first;
  } entry_t;

  // The microprogram. Steps not listed fall back to the wait step.
  function automatic uword_t ucode_rom(step_t step);
    uword_t w;
    unique case (step)
      STEP_WAIT:  w = '{op: OP_WAIT,  cond: COND_START,      target: STEP_SWEEP};
      STEP_DIV:   w = '{op: OP_DIV,   cond: COND_DIV_LOOP,   target: STEP_DIV};
      STEP_ADD:   w = '{op: OP_ADD,   cond: COND_NEXT,       target: STEP_WAIT};
      STEP_UPD:   w = '{op: OP_UPD,   cond: COND_NEXT,       target: STEP_WAIT};
      STEP_END:   w = '{op: OP_EMIT,  cond: COND_EMIT,       target: STEP_WAIT};
      STEP_SWEEP: w = '{op: OP_SWEEP, cond: COND_SWEEP_LOOP, target: STEP_WAIT};
      default:    w = '{op: OP_NOP,   cond: COND_GOTO,       target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/dsf_ram.sv =====
// ----------------------------------------------------------------------------
// dsf_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module dsf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/dsf_sequencer.sv =====
// ----------------------------------------------------------------------------
// dsf_sequencer: microcode step counter
// Fetches one control word per step from the program table and picks the
// next step from the word's jump condition and the datapath status.
// ----------------------------------------------------------------------------
module dsf_sequencer import dsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  seq_status_t status_i,
  output op_e         op_o
);

  step_t  pc_q, pc_d;
  uword_t uw;

  assign uw   = ucode_rom(pc_q);
  assign op_o = uw.op;

  always_comb begin
    unique case (uw.cond)
      COND_NEXT:       pc_d = pc_q + 1'b1;
      COND_GOTO:       pc_d = uw.target;
      COND_START: begin
        if (status_i.sweep_pend) begin
          pc_d = uw.target;
        end else if (status_i.in_go) begin
          pc_d = pc_q + 1'b1;
        end else begin
          pc_d = pc_q;
        end
      end
      COND_DIV_LOOP:   pc_d = status_i.div_more ? uw.target : pc_q + 1'b1;
      COND_EMIT:       pc_d = status_i.hold_emit ? pc_q : uw.target;
      COND_SWEEP_LOOP: pc_d = status_i.sweep_last ? uw.target : pc_q;
      default:         pc_d = STEP_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== sv/dsf_datapath.sv =====
// ----------------------------------------------------------------------------
// dsf_datapath: remainder unit, residue table and result register
// Executes the operation of the current microcode step: a bit-serial
// remainder, the residue update, the table lookup, the result hand-off and the table sweep.
// ----------------------------------------------------------------------------
module dsf_datapath import dsf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  op_e                   op_i,
  input  logic [DIV_W-1:0]      divisor_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  set_end_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  found_o,
  output logic [POS_W-1:0]      run_start_o,
  output logic [POS_W-1:0]      run_end_o,
  output seq_status_t           status_o
);

  localparam logic [DIV_W-1:0] DIV_ONE  = DIV_W'(1);
  localparam logic [DIV_W-1:0] DIV_MAX  = DIV_W'(MAX_DIVISOR);
  localparam logic [POS_W-1:0] POS_SAT  = POS_W'(MAX_SET_LEN);

  // Request and remainder registers.
  logic [DVD_W-1:0]      val_q, val_d;
  logic                  last_q, last_d;
  logic [BIT_CNT_W-1:0]  bit_cnt_q, bit_cnt_d;
  logic [DIV_W-1:0]      rem_q, rem_d;

  // Per-set state.
  logic [RES_W-1:0]      res_q, res_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic                  hit_q, hit_d;
  logic [POS_W-1:0]      best_start_q, best_start_d;
  logic [POS_W-1:0]      best_end_q, best_end_d;

  // Table bookkeeping.
  logic [EPOCH_W-1:0]    epoch_q, epoch_d;
  logic                  sweep_pend_q, sweep_pend_d;
  logic [RES_W-1:0]      sweep_cnt_q, sweep_cnt_d;

  // Result register.
  logic                  out_valid_q, out_valid_d;
  logic                  found_q, found_d;
  logic [POS_W-1:0]      run_start_q, run_start_d;
  logic [POS_W-1:0]      run_end_q, run_end_d;

  logic [DIV_W-1:0]      d_eff;
  logic [DIV_W:0]        trial;
  logic [RES_W-1:0]      new_res;
  logic                  sat;
  logic                  in_go;
  logic                  hold_emit;
  logic                  emit;
  logic                  ram_we;
  logic [RES_W-1:0]      ram_waddr;
  entry_t                ram_wdata;
  entry_t                ram_rdata;
  logic [ENTRY_W-1:0]    ram_rword;

  always_comb begin
    if (divisor_i == '0) begin
      d_eff = DIV_ONE;
    end else if (divisor_i > DIV_MAX) begin
      d_eff = DIV_MAX;
    end else begin
      d_eff = divisor_i;
    end
  end

  assign in_stall_o = !((op_i == OP_WAIT) && !sweep_pend_q);
  assign in_go      = in_valid_i && !in_stall_o;
  assign sat        = (pos_q == POS_SAT);
  assign hold_emit  = last_q && out_valid_q && out_stall_i;
  assign emit       = (op_i == OP_EMIT) && last_q && !hold_emit;

  // One restoring step: the partial remainder stays below the divisor.
  assign trial = {rem_q, val_q[DVD_W-1]};
  // The remainder is below the divisor, so it fits the residue width.
  assign new_res = RES_W'(rem_q);

  assign ram_rdata = entry_t'(ram_rword);

  always_comb begin
    val_d        = val_q;
    last_d       = last_q;
    bit_cnt_d    = bit_cnt_q;
    rem_d        = rem_q;
    res_d        = res_q;
    pos_d        = pos_q;
    hit_d        = hit_q;
    best_start_d = best_start_q;
    best_end_d   = best_end_q;
    epoch_d      = epoch_q;
    sweep_pend_d = sweep_pend_q;
    sweep_cnt_d  = sweep_cnt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    found_d      = found_q;
    run_start_d  = run_start_q;
    run_end_d    = run_end_q;
    ram_we       = 1'b0;
    ram_waddr    = res_q;
    ram_wdata    = '{epoch: epoch_q, first: FIRST_W'(pos_q)};

    unique case (op_i)
      OP_WAIT: begin
        if (in_go) begin
          // The old residue joins the value, so a single remainder is correct
          // even when the residue came from a larger divisor.
          val_d     = {1'b0, value_i} + DVD_W'(res_q);
          last_d    = set_end_i;
          bit_cnt_d = BIT_CNT_W'(DVD_W - 1);
          rem_d     = '0;
        end
      end
      OP_DIV: begin
        if (trial >= {1'b0, d_eff}) begin
          rem_d = DIV_W'(trial - {1'b0, d_eff});
        end else begin
          rem_d = DIV_W'(trial);
        end
        val_d     = val_q << 1;
        bit_cnt_d = bit_cnt_q - 1'b1;
      end
      OP_ADD: begin
        if (!sat) begin
          res_d = new_res;
        end
      end
      OP_UPD: begin
        if (!sat) begin
          if (res_q == '0) begin
            hit_d        = 1'b1;
            best_start_d = POS_W'(1);
            best_end_d   = pos_q + 1'b1;
          end else if (ram_rdata.epoch == epoch_q) begin
            hit_d        = 1'b1;
            best_start_d = {1'b0, ram_rdata.first} + POS_W'(2);
            best_end_d   = pos_q + 1'b1;
          end else begin
            ram_we = 1'b1;
          end
          pos_d = pos_q + 1'b1;
        end
      end
      OP_EMIT: begin
        if (emit) begin
          out_valid_d  = 1'b1;
          found_d      = hit_q;
          run_start_d  = hit_q ? best_start_q : '0;
          run_end_d    = hit_q ? best_end_q : '0;
          res_d        = '0;
          pos_d        = '0;
          hit_d        = 1'b0;
          best_start_d = '0;
          best_end_d   = '0;
          // A fresh epoch retires every entry of the finished set.
          if (epoch_q == '1) begin
            sweep_pend_d = 1'b1;
          end else begin
            epoch_d = epoch_q + 1'b1;
          end
        end
      end
      OP_SWEEP: begin
        ram_we      = 1'b1;
        ram_waddr   = sweep_cnt_q;
        ram_wdata   = '{epoch: '0, first: '0};
        sweep_cnt_d = sweep_cnt_q + 1'b1;
        if (sweep_cnt_q == '1) begin
          sweep_pend_d = 1'b0;
          epoch_d      = EPOCH_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  dsf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_DIVISOR)
  ) u_first_seen (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (op_i == OP_ADD),
    .raddr_i(new_res),
    .rdata_o(ram_rword)
  );

  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    bit_cnt_q   <= bit_cnt_d;
    rem_q       <= rem_d;
    found_q     <= found_d;
    run_start_q <= run_start_d;
    run_end_q   <= run_end_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q       <= 1'b0;
      res_q        <= '0;
      pos_q        <= '0;
      hit_q        <= 1'b0;
      best_start_q <= '0;
      best_end_q   <= '0;
      epoch_q      <= EPOCH_W'(1);
      sweep_pend_q <= 1'b1;
      sweep_cnt_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      last_q       <= last_d;
      res_q        <= res_d;
      pos_q        <= pos_d;
      hit_q        <= hit_d;
      best_start_q <= best_start_d;
      best_end_q   <= best_end_d;
      epoch_q      <= epoch_d;
      sweep_pend_q <= sweep_pend_d;
      sweep_cnt_q  <= sweep_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign run_start_o = run_start_q;
  assign run_end_o   = run_end_q;

  assign status_o = '{
    sweep_pend: sweep_pend_q,
    in_go:      in_go,
    div_more:   (bit_cnt_q != '0),
    hold_emit:  hold_emit,
    sweep_last: (sweep_cnt_q == '1)
  };

endmodule

// ===== sv/divisible_subarray_finder.sv =====
// ----------------------------------------------------------------------------
// divisible_subarray_finder: divisible contiguous run finder
// Tracks the prefix sum of each set modulo a programmable divisor and
// reports the latest run whose sum the divisor divides.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  value, set_end
//   out      output     out_valid/out_stall  found, run_start, run_end
//   cfg      input      APB write/read       divisor (byte address 0)
//
// Each request is accepted in the wait step, then runs 33 iterations of the
// bit-serial remainder unit (one per bit of the value plus the old residue),
// a residue update, a table update and a step that hands off the result on
// the last item of a set.
// After reset all 4096 entries of the residue table are swept before the
// first request is taken; the same sweep runs again after every 65535 sets.
// A set's last item waits in its final step while the result register is
// still held by out_stall; other items pass it by.
// ----------------------------------------------------------------------------
module divisible_subarray_finder import dsf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  set_end_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  found_o,
  output logic [POS_W-1:0]      run_start_o,
  output logic [POS_W-1:0]      run_end_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  logic [DIV_W-1:0] divisor_q, divisor_d;
  seq_status_t      status;
  op_e              op;

  always_comb begin
    divisor_d = divisor_q;
    if (psel && penable && pwrite && (paddr == REG_DIVISOR)) begin
      divisor_d = pwdata[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q <= DIV_W'(1);
    end else begin
      divisor_q <= divisor_d;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_DIVISOR) ? DATA_W'(divisor_q) : '0;

  dsf_sequencer u_sequencer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(status),
    .op_o    (op)
  );

  dsf_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .divisor_i  (divisor_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .set_end_i  (set_end_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .found_o    (found_o),
    .run_start_o(run_start_o),
    .run_end_o  (run_end_o),
    .status_o   (status)
  );

endmodule
